// ===== rtl/kbs_pkg.sv =====
// ----------------------------------------------------------------------------
// kbs_pkg
// Shared constants, command and status types for the bicycle model stepper.
// ----------------------------------------------------------------------------
package kbs_pkg;

  localparam logic signed [16:0] ANG_PI      = 17'sd25736;
  localparam logic signed [16:0] ANG_TWO_PI  = 17'sd51472;
  localparam logic signed [20:0] PI_Q16      = 21'sd205887;
  localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam int CORDIC_STEPS = 16;
  localparam int DIV_BITS     = 15;
  localparam logic [14:0] TAN_MAX = 15'd25736;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_CLAMP   = 2'd1;
  localparam logic [1:0] OP_PREDICT = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [2:0] CFG_WHEELBASE     = 3'd0;
  localparam logic [2:0] CFG_STEER_LIMIT   = 3'd1;
  localparam logic [2:0] CFG_SPEED_FLOOR   = 3'd2;
  localparam logic [2:0] CFG_SPEED_CEILING = 3'd3;
  localparam logic [2:0] CFG_TIME_STEP     = 3'd4;

  localparam logic [1:0] MUL_VDT = 2'd0;
  localparam logic [1:0] MUL_X   = 2'd1;
  localparam logic [1:0] MUL_Y   = 2'd2;
  localparam logic [1:0] MUL_TAN = 2'd3;

  localparam logic SRC_HEADING = 1'b0;
  localparam logic SRC_STEER   = 1'b1;
  localparam logic DIV_TAN     = 1'b0;
  localparam logic DIV_INC     = 1'b1;

  typedef struct packed {
    logic       latch;
    logic       cor_init;
    logic       cor_sel;
    logic       cor_step;
    logic       cor_cap;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       vdt_ld;
    logic       add_x;
    logic       add_y;
    logic       div_init;
    logic       div_sel;
    logic       div_step;
    logic       tan_cap;
    logic       inc_cap;
    logic       fin;
    logic [3:0] iter;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // arctangent of 2^-i in Q1.16
  function automatic logic [16:0] atan_q16(input logic [3:0] i);
    logic [16:0] r;
    case (i)
      4'd0:    r = 17'd51472;
      4'd1:    r = 17'd30385;
      4'd2:    r = 17'd16055;
      4'd3:    r = 17'd8150;
      4'd4:    r = 17'd4091;
      4'd5:    r = 17'd2047;
      4'd6:    r = 17'd1024;
      4'd7:    r = 17'd512;
      4'd8:    r = 17'd256;
      4'd9:    r = 17'd128;
      4'd10:   r = 17'd64;
      4'd11:   r = 17'd32;
      4'd12:   r = 17'd16;
      4'd13:   r = 17'd8;
      4'd14:   r = 17'd4;
      4'd15:   r = 17'd2;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/kbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// kbs_ctrl
// Sequencer: steps the datapath through CORDIC, multiply and divide phases.
// ----------------------------------------------------------------------------
module kbs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     opcode,
  input  kbs_pkg::stat_t stat,
  output kbs_pkg::cmd_t  cmd
);
  import kbs_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_COR1I = 5'd1;
  localparam logic [4:0] S_COR1  = 5'd2;
  localparam logic [4:0] S_CAP1  = 5'd3;
  localparam logic [4:0] S_VDT   = 5'd4;
  localparam logic [4:0] S_VDTS  = 5'd5;
  localparam logic [4:0] S_MX    = 5'd6;
  localparam logic [4:0] S_MY    = 5'd7;
  localparam logic [4:0] S_ADDY  = 5'd8;
  localparam logic [4:0] S_COR2  = 5'd9;
  localparam logic [4:0] S_CAP2  = 5'd10;
  localparam logic [4:0] S_DIV1I = 5'd11;
  localparam logic [4:0] S_DIV1  = 5'd12;
  localparam logic [4:0] S_TAN   = 5'd13;
  localparam logic [4:0] S_MT    = 5'd14;
  localparam logic [4:0] S_DIV2I = 5'd15;
  localparam logic [4:0] S_DIV2  = 5'd16;
  localparam logic [4:0] S_INC   = 5'd17;
  localparam logic [4:0] S_FIN   = 5'd18;

  localparam logic [3:0] COR_LAST = 4'(CORDIC_STEPS - 1);
  localparam logic [3:0] DIV_LAST = 4'(DIV_BITS - 1);

  logic [4:0] state, state_next;
  logic [3:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.iter   = cnt;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = (opcode inside {OP_CLAMP, OP_PREDICT}) ? S_COR1I : S_FIN;
        end
      end
      S_COR1I: begin
        cmd.cor_init = 1'b1;
        cmd.cor_sel  = SRC_HEADING;
        cnt_next     = '0;
        state_next   = S_COR1;
      end
      S_COR1: begin
        cmd.cor_step = 1'b1;
        cnt_next     = cnt + 4'd1;
        if (cnt == COR_LAST) state_next = S_CAP1;
      end
      S_CAP1: begin
        cmd.cor_cap = 1'b1;
        state_next  = S_VDT;
      end
      S_VDT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VDT;
        state_next  = S_VDTS;
      end
      S_VDTS: begin
        cmd.vdt_ld = 1'b1;
        state_next = S_MX;
      end
      S_MX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_X;
        state_next  = S_MY;
      end
      S_MY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Y;
        cmd.add_x   = 1'b1;
        state_next  = S_ADDY;
      end
      S_ADDY: begin
        cmd.add_y    = 1'b1;
        cmd.cor_init = 1'b1;
        cmd.cor_sel  = SRC_STEER;
        cnt_next     = '0;
        state_next   = S_COR2;
      end
      S_COR2: begin
        cmd.cor_step = 1'b1;
        cnt_next     = cnt + 4'd1;
        if (cnt == COR_LAST) state_next = S_CAP2;
      end
      S_CAP2: begin
        cmd.cor_cap = 1'b1;
        state_next  = S_DIV1I;
      end
      S_DIV1I: begin
        cmd.div_init = 1'b1;
        cmd.div_sel  = DIV_TAN;
        cnt_next     = '0;
        state_next   = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 4'd1;
        if (cnt == DIV_LAST) state_next = S_TAN;
      end
      S_TAN: begin
        cmd.tan_cap = 1'b1;
        state_next  = S_MT;
      end
      S_MT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TAN;
        state_next  = S_DIV2I;
      end
      S_DIV2I: begin
        cmd.div_init = 1'b1;
        cmd.div_sel  = DIV_INC;
        cnt_next     = '0;
        state_next   = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 4'd1;
        if (cnt == DIV_LAST) state_next = S_INC;
      end
      S_INC: begin
        cmd.inc_cap = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the word
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== rtl/kbs_datapath.sv =====
// ----------------------------------------------------------------------------
// kbs_datapath
// State, configuration, shared CORDIC, multiplier, divider and output word.
// ----------------------------------------------------------------------------
module kbs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  kbs_pkg::cmd_t       cmd,
  output kbs_pkg::stat_t      stat,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [1:0]          opcode,
  input  logic signed [15:0]  steer_set,
  input  logic signed [15:0]  speed_set,
  input  logic signed [31:0]  load_x,
  input  logic signed [31:0]  load_y,
  input  logic signed [15:0]  load_heading,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [15:0]  out_heading,
  output logic signed [15:0]  out_speed,
  output logic signed [15:0]  out_steering,
  output logic                saturated
);
  import kbs_pkg::*;

  logic [15:0]        wheelbase;
  logic [13:0]        steer_limit;
  logic signed [15:0] speed_floor, speed_ceiling;
  logic [15:0]        time_step;

  logic signed [31:0] x_pos, y_pos;
  logic signed [15:0] heading, cur_speed, cur_steer;
  logic               op_step;
  logic signed [15:0] new_steer, new_speed;

  logic signed [33:0] cx, cy, c_reg, s_reg;
  logic signed [20:0] cz;
  logic               cneg;
  logic signed [67:0] prod;
  logic signed [33:0] vdt;
  logic [46:0]        dsh, drem;
  logic [14:0]        dq;
  logic               dovf, dneg;
  logic signed [15:0] tanv, inc;
  logic               sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheelbase     <= 16'd256;
      steer_limit   <= 14'd4096;
      speed_floor   <= 16'sd0;
      speed_ceiling <= 16'sd512;
      time_step     <= 16'd655;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WHEELBASE:     wheelbase     <= cfg_data;
        CFG_STEER_LIMIT:   steer_limit   <= cfg_data[13:0];
        CFG_SPEED_FLOOR:   speed_floor   <= cfg_data;
        CFG_SPEED_CEILING: speed_ceiling <= cfg_data;
        CFG_TIME_STEP:     time_step     <= cfg_data;
        default: ;
      endcase
    end
  end

  // command limiting on a clamped step
  logic signed [15:0] lim, steer_cl, speed_hi, speed_cl;
  always_comb begin
    lim = {2'b00, steer_limit};
    steer_cl = steer_set;
    if (steer_set > lim) steer_cl = lim;
    if (steer_set < -lim) steer_cl = -lim;
    speed_hi = (speed_set > speed_ceiling) ? speed_ceiling : speed_set;
    speed_cl = (speed_hi < speed_floor) ? speed_floor : speed_hi;
  end

  // CORDIC init and iteration
  logic signed [15:0] cor_ang;
  logic signed [20:0] z0, z_fold;
  logic               fold;
  logic signed [33:0] cx_n, cy_n;
  logic signed [20:0] cz_n, atn;
  always_comb begin
    cor_ang = (cmd.cor_sel == SRC_STEER) ? new_steer : heading;
    z0 = 21'(cor_ang) <<< 3;
    fold = 1'b0;
    z_fold = z0;
    if (z0 > HALF_PI_Q16) begin
      z_fold = z0 - PI_Q16;
      fold = 1'b1;
    end else if (z0 < -HALF_PI_Q16) begin
      z_fold = z0 + PI_Q16;
      fold = 1'b1;
    end
    atn = 21'(signed'({1'b0, atan_q16(cmd.iter)}));
    if (cz >= 0) begin
      cx_n = cx - (cy >>> cmd.iter);
      cy_n = cy + (cx >>> cmd.iter);
      cz_n = cz - atn;
    end else begin
      cx_n = cx + (cy >>> cmd.iter);
      cy_n = cy - (cx >>> cmd.iter);
      cz_n = cz + atn;
    end
  end

  // shared multiplier operands
  logic signed [33:0] mul_a, mul_b;
  always_comb begin
    mul_a = vdt;
    case (cmd.mul_sel)
      MUL_VDT: begin
        mul_a = 34'(cur_speed);
        mul_b = {18'b0, time_step};
      end
      MUL_X:   mul_b = c_reg;
      MUL_Y:   mul_b = s_reg;
      MUL_TAN: mul_b = 34'(tanv);
      default: mul_b = c_reg;
    endcase
  end

  // divider setup: magnitudes, sign and overflow
  logic signed [33:0] ms_s, mc_s;
  logic signed [67:0] prod_abs;
  logic [15:0]        wb_eff;
  logic [46:0]        div_num;
  logic [31:0]        div_den;
  logic               div_neg;
  always_comb begin
    ms_s = (s_reg < 0) ? -s_reg : s_reg;
    mc_s = (c_reg < 0) ? -c_reg : c_reg;
    prod_abs = (prod < 0) ? -prod : prod;
    wb_eff = (wheelbase == 16'd0) ? 16'd1 : wheelbase;
    if (cmd.div_sel == DIV_TAN) begin
      div_num = {2'b00, ms_s[31:0], 13'b0};
      div_den = mc_s[31:0];
      div_neg = (s_reg < 0) != (c_reg < 0);
    end else begin
      div_num = prod_abs[46:0];
      div_den = {wb_eff, 16'b0};
      div_neg = prod < 0;
    end
  end

  logic        tan_sat, inc_sat;
  logic [15:0] q_ext;
  always_comb begin
    q_ext   = {1'b0, dq};
    tan_sat = dovf || (dq > TAN_MAX) || ((dq == TAN_MAX) && (drem != '0));
    inc_sat = dovf || (dq > TAN_MAX);
  end

  // heading update and next state for the output word
  logic signed [16:0] h_sum;
  logic signed [15:0] h_next, sp_next, st_next;
  always_comb begin
    h_sum = 17'(heading) + 17'(inc);
    if (h_sum > ANG_PI) h_sum = h_sum - ANG_TWO_PI;
    else if (h_sum < -ANG_PI) h_sum = h_sum + ANG_TWO_PI;
    h_next  = op_step ? h_sum[15:0] : heading;
    sp_next = op_step ? new_speed : cur_speed;
    st_next = op_step ? new_steer : cur_steer;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_pos     <= '0;
      y_pos     <= '0;
      heading   <= '0;
      cur_speed <= '0;
      cur_steer <= '0;
      op_step   <= 1'b0;
      sat       <= 1'b0;
    end else begin
      if (cmd.latch) begin
        sat       <= 1'b0;
        op_step   <= opcode inside {OP_CLAMP, OP_PREDICT};
        new_steer <= (opcode == OP_CLAMP) ? steer_cl : steer_set;
        new_speed <= (opcode == OP_CLAMP) ? speed_cl : speed_set;
        if (opcode == OP_LOAD) begin
          x_pos     <= load_x;
          y_pos     <= load_y;
          heading   <= load_heading;
          cur_speed <= speed_set;
          cur_steer <= steer_set;
        end
      end
      if (cmd.add_x) x_pos <= x_pos + {{2{prod[67]}}, prod[67:38]};
      if (cmd.add_y) y_pos <= y_pos + {{2{prod[67]}}, prod[67:38]};
      if (cmd.tan_cap && tan_sat) sat <= 1'b1;
      if (cmd.inc_cap && inc_sat) sat <= 1'b1;
      if (cmd.fin) begin
        heading   <= h_next;
        cur_speed <= sp_next;
        cur_steer <= st_next;
      end
    end
  end

  // datapath working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.cor_init) begin
      cx   <= CORDIC_GAIN;
      cy   <= '0;
      cz   <= z_fold;
      cneg <= fold;
    end else if (cmd.cor_step) begin
      cx <= cx_n;
      cy <= cy_n;
      cz <= cz_n;
    end
    if (cmd.cor_cap) begin
      c_reg <= cneg ? -cx : cx;
      s_reg <= cneg ? -cy : cy;
    end
    if (cmd.mul_en) prod <= mul_a * mul_b;
    if (cmd.vdt_ld) vdt <= prod[33:0];
    if (cmd.div_init) begin
      drem <= div_num;
      dsh  <= {1'b0, div_den, 14'b0};
      dq   <= '0;
      dneg <= div_neg;
      dovf <= {1'b0, div_num} >= {1'b0, div_den, 15'b0};
    end else if (cmd.div_step) begin
      if (drem >= dsh) begin
        drem <= drem - dsh;
        dq   <= {dq[13:0], 1'b1};
      end else begin
        dq <= {dq[13:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
    if (cmd.tan_cap) begin
      if (tan_sat) tanv <= dneg ? -ANG_PI[15:0] : ANG_PI[15:0];
      else         tanv <= dneg ? -signed'(q_ext) : signed'(q_ext);
    end
    if (cmd.inc_cap) begin
      if (inc_sat) inc <= dneg ? -ANG_PI[15:0] : ANG_PI[15:0];
      else         inc <= dneg ? -signed'(q_ext) : signed'(q_ext);
    end
  end

  // output register
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_x        <= x_pos;
      out_y        <= y_pos;
      out_heading  <= h_next;
      out_speed    <= sp_next;
      out_steering <= st_next;
      saturated    <= sat;
    end
  end

endmodule

// ===== rtl/kinematic_bicycle_step.sv =====
// ----------------------------------------------------------------------------
// kinematic_bicycle_step
// Fixed-point kinematic bicycle model: one Euler step, load or no-op per word.
// A step runs two 16-iteration CORDIC passes and two 15-bit restoring
//   divisions on the shared units. One item in flight at a time: a new word
//   is taken only after the last result has entered the output register,
//   and that waits for any output stall.
// Reset: synchronous; clears the vehicle state and sets the registers to
//   their defaults. The output register takes each result when it is free.
// ----------------------------------------------------------------------------
module kinematic_bicycle_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic signed [15:0] steer_set,
  input  logic signed [15:0] speed_set,
  input  logic signed [31:0] load_x,
  input  logic signed [31:0] load_y,
  input  logic signed [15:0] load_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [15:0] out_heading,
  output logic signed [15:0] out_speed,
  output logic signed [15:0] out_steering,
  output logic               saturated
);
  import kbs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  kbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .stat     (stat),
    .cmd      (cmd)
  );

  kbs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .opcode       (opcode),
    .steer_set    (steer_set),
    .speed_set    (speed_set),
    .load_x       (load_x),
    .load_y       (load_y),
    .load_heading (load_heading),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_heading  (out_heading),
    .out_speed    (out_speed),
    .out_steering (out_steering),
    .saturated    (saturated)
  );

endmodule
